// ===== rtl/gdcd_pkg.sv =====
package gdcd_pkg;

	localparam int MAX_NODES = 16;
	localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int TAYLOR_TERMS = 13;
	localparam int TERM_W = $clog2(TAYLOR_TERMS + 2);
	localparam int S_W = 41 + $clog2(MAX_NODES) + 1;
	localparam int D_W = 44 + $clog2(MAX_NODES) + 1;
	localparam int CFG_IDX_W = 3;

	localparam logic [31:0] EXP_M1_Q32 = 32'd1580030169;
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [32:0] HALF_Q32 = 33'h0_8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NODE_COUNT       = 3'd0,
		REG_Q_OVER_KT        = 3'd1,
		REG_NODE_SCALE       = 3'd2,
		REG_CHARGE_SCALE     = 3'd3,
		REG_DERIVATIVE_SCALE = 3'd4
	} reg_index_t;

	typedef enum logic [3:0] {
		OP_LOAD,
		OP_VOLT,
		OP_READ,
		OP_ARG,
		OP_FLAGS,
		OP_TERM_MUL,
		OP_TERM_DIV,
		OP_CLAMP,
		OP_EXP_STEP,
		OP_RECIP,
		OP_WEIGHT,
		OP_MOMENT,
		OP_NEXT,
		OP_CHARGE,
		OP_DERIV,
		OP_PUSH
	} op_t;

	typedef struct packed {
		logic capture;
		logic start;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic no_nodes;
		logic node_last;
		logic term_end;
		logic k_zero;
		logic saturated;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/gdcd_in_if.sv =====
interface gdcd_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [3:0]         node_index;
	logic signed [31:0] node_value;
	logic [31:0]        node_weight;
	logic signed [31:0] voltage;

	modport source (
		output valid, operation, node_index, node_value, node_weight, voltage,
		input  ready
	);
	modport sink (
		input  valid, operation, node_index, node_value, node_weight, voltage,
		output ready
	);
endinterface

// ===== rtl/gdcd_out_if.sv =====
interface gdcd_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] charge_density;
	logic signed [47:0] charge_derivative;

	modport source (
		output valid, charge_density, charge_derivative,
		input  ready
	);
	modport sink (
		input  valid, charge_density, charge_derivative,
		output ready
	);
endinterface

// ===== rtl/gaussian_dos_charge_density.sv =====
// Gaussian density-of-states charge density by Gauss-Hermite quadrature.
// in_ch carries one item per transfer: operation 1 writes node_value and
// node_weight into table slot node_index, operation 0 evaluates one voltage
// sample against the first node_count slots and yields one out_ch transfer
// with charge_density and charge_derivative (Q16.32, saturating).
// cfg_we/cfg_index/cfg_data write the five scale and count registers.
// Items are taken one at a time; in_ch.ready is high while the sequencer idles.
// Per node, an evaluate runs a Taylor series, k exponent steps (k the
// integer part of the Fermi argument) and a reciprocal; the reciprocal is
// skipped when the argument is zero, and all of these when it lies at or
// beyond +-32; the last node skips the index step. Every multiply holds
// the shared 64x32 unit (two 32x32 partial products); each Taylor term is
// a multiply and a reciprocal multiply by 1/n, and the final reciprocal
// runs on a bit-serial divider.
// The result sits in an output register; a new item is taken while it waits,
// and only the final push of the next evaluate stalls until out_ch drains it.
// Reset restores the register defaults and clears all handshake state; the
// node tables are not cleared and must be loaded before they are used.
module gaussian_dos_charge_density (
	input  logic                           clk,
	input  logic                           arst_n,
	gdcd_in_if.sink                        in_ch,
	gdcd_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [gdcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	gdcd_pkg::cmd_t    cmd;
	gdcd_pkg::status_t status;

	gdcd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_operation (in_ch.operation),
		.in_ready     (in_ch.ready),
		.status       (status),
		.cmd          (cmd)
	);

	gdcd_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.node_index        (in_ch.node_index),
		.node_value        (in_ch.node_value),
		.node_weight       (in_ch.node_weight),
		.voltage           (in_ch.voltage),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.out_valid         (out_ch.valid),
		.out_ready         (out_ch.ready),
		.charge_density    (out_ch.charge_density),
		.charge_derivative (out_ch.charge_derivative)
	);

endmodule

// ===== rtl/gdcd_mul.sv =====
module gdcd_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [95:0] prod
);

	typedef enum logic [1:0] {MS_IDLE, MS_LO, MS_HI, MS_SUM} mstate_t;

	mstate_t     state_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [31:0] b_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	logic [95:0] prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MS_IDLE: if (start) state_q <= MS_LO;
				MS_LO:   state_q <= MS_HI;
				MS_HI:   state_q <= MS_SUM;
				MS_SUM: begin
					state_q <= MS_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= MS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == MS_IDLE) begin
			a_q <= a;
			b_q <= b;
		end
		if (state_q == MS_LO) lo_q <= a_q[31:0] * b_q;
		if (state_q == MS_HI) hi_q <= a_q[63:32] * b_q;
		if (state_q == MS_SUM) prod_q <= {32'd0, lo_q} + {hi_q, 32'd0};
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// ===== rtl/gdcd_div.sv =====
module gdcd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] rem_init,
	input  logic [32:0] low_bits,
	input  logic [5:0]  nbits,
	input  logic [32:0] divisor,
	output logic        done,
	output logic [32:0] quot
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [32:0] sh_q;
	logic [32:0] dv_q;
	logic [33:0] rem2;
	logic [33:0] diff;
	logic        ge;

	assign rem2 = {rem_q, sh_q[32]};
	assign diff = rem2 - {1'b0, dv_q};
	assign ge   = rem2 >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= rem_init;
			sh_q  <= low_bits;
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[32:0] : rem2[32:0];
			sh_q  <= {sh_q[31:0], ge};
		end
	end

	assign done = done_q;
	assign quot = sh_q;

endmodule

// ===== rtl/gdcd_datapath.sv =====
module gdcd_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gdcd_pkg::cmd_t                     cmd,
	output gdcd_pkg::status_t                  status,
	input  logic [3:0]                         node_index,
	input  logic signed [31:0]                 node_value,
	input  logic [31:0]                        node_weight,
	input  logic signed [31:0]                 voltage,
	input  logic                               cfg_we,
	input  logic [gdcd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [47:0]                 charge_density,
	output logic signed [47:0]                 charge_derivative
);

	localparam logic signed [63:0] FERMI_LIM = 64'sh20_0000_0000;

	logic [4:0]  count_cfg_q;
	logic [31:0] qkt_q;
	logic [31:0] nscale_q;
	logic [31:0] cscale_q;
	logic [31:0] dscale_q;

	logic [3:0]  ld_idx_q;
	logic [31:0] ld_val_q;
	logic [31:0] ld_wgt_q;
	logic [31:0] volt_q;

	logic [31:0] val_mem [gdcd_pkg::MAX_NODES];
	logic [31:0] wgt_mem [gdcd_pkg::MAX_NODES];

	gdcd_pkg::op_t op_q;
	logic done_q;
	logic out_valid_q;

	logic [gdcd_pkg::IDX_W-1:0]  idx_q;
	logic [31:0]                 x_q;
	logic [31:0]                 w_q;
	logic [60:0]                 bmag_q;
	logic signed [63:0]          c_q;
	logic                        cneg_q;
	logic                        sat_q;
	logic [31:0]                 r_q;
	logic [4:0]                  k_q;
	logic [4:0]                  kc_q;
	logic [32:0]                 term_q;
	logic [31:0]                 tmp_q;
	logic signed [35:0]          sum_q;
	logic [gdcd_pkg::TERM_W-1:0] n_q;
	logic [32:0]                 e_q;
	logic [32:0]                 f_q;
	logic [40:0]                 p_q;
	logic [gdcd_pkg::S_W-1:0]    s_q;
	logic signed [gdcd_pkg::D_W-1:0] d_q;
	logic [47:0]                 res_c_q;
	logic [47:0]                 res_d_q;
	logic [47:0]                 out_c_q;
	logic [47:0]                 out_d_q;

	logic [gdcd_pkg::CNT_W-1:0] count_eff;
	logic                       vneg;
	logic [31:0]                vmag;
	logic                       xneg;
	logic [31:0]                xmag;
	logic [gdcd_pkg::D_W-1:0]   dmag;
	logic signed [63:0]         a_s;
	logic signed [63:0]         b_s;
	logic [63:0]                cmag_u;
	logic [32:0]                e_clamp;
	logic                       load_ok;
	logic                       single_op;

	logic        mul_start;
	logic [63:0] mul_a;
	logic [31:0] mul_b;
	logic        mul_done;
	logic [95:0] prod;
	logic        over;
	logic [47:0] mag48;

	logic        div_start;
	logic [32:0] div_rem;
	logic [32:0] div_low;
	logic [5:0]  div_nbits;
	logic [32:0] div_dv;
	logic        div_done;
	logic [32:0] quot;

	// ceil(2^40 / n), exact floor division of a 32-bit term by n after >> 40
	function automatic logic [63:0] term_recip(input logic [gdcd_pkg::TERM_W-1:0] n);
		logic [63:0] m;
		unique case (n)
			4'd1:    m = 64'd1099511627776;
			4'd2:    m = 64'd549755813888;
			4'd3:    m = 64'd366503875926;
			4'd4:    m = 64'd274877906944;
			4'd5:    m = 64'd219902325556;
			4'd6:    m = 64'd183251937963;
			4'd7:    m = 64'd157073089683;
			4'd8:    m = 64'd137438953472;
			4'd9:    m = 64'd122167958642;
			4'd10:   m = 64'd109951162778;
			4'd11:   m = 64'd99955602526;
			4'd12:   m = 64'd91625968982;
			4'd13:   m = 64'd84577817522;
			default: m = 64'd0;
		endcase
		return m;
	endfunction

	assign count_eff = (32'(count_cfg_q) > gdcd_pkg::MAX_NODES)
		? gdcd_pkg::CNT_W'(gdcd_pkg::MAX_NODES) : gdcd_pkg::CNT_W'(count_cfg_q);
	assign vneg   = volt_q[31];
	assign vmag   = vneg ? (32'd0 - volt_q) : volt_q;
	assign xneg   = x_q[31];
	assign xmag   = xneg ? (32'd0 - x_q) : x_q;
	assign dmag   = d_q[gdcd_pkg::D_W-1] ? gdcd_pkg::D_W'(-d_q) : gdcd_pkg::D_W'(d_q);
	assign a_s    = xneg ? -$signed({13'd0, prod[62:12]}) : $signed({13'd0, prod[62:12]});
	assign b_s    = vneg ? -$signed({3'd0, bmag_q}) : $signed({3'd0, bmag_q});
	assign cmag_u = c_q[63] ? 64'(-c_q) : 64'(c_q);
	assign load_ok = 32'(ld_idx_q) < gdcd_pkg::MAX_NODES;
	assign over   = |prod[95:71];
	assign mag48  = {1'b0, prod[70:24]};

	always_comb begin
		if (sum_q[35]) begin
			e_clamp = '0;
		end else if (sum_q > $signed({3'd0, gdcd_pkg::ONE_Q32})) begin
			e_clamp = gdcd_pkg::ONE_Q32;
		end else begin
			e_clamp = sum_q[32:0];
		end
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (cmd.op)
			gdcd_pkg::OP_VOLT:     begin mul_a = 64'(vmag);   mul_b = qkt_q;      end
			gdcd_pkg::OP_ARG:      begin mul_a = 64'(xmag);   mul_b = nscale_q;   end
			gdcd_pkg::OP_TERM_MUL: begin mul_a = 64'(term_q); mul_b = r_q;        end
			gdcd_pkg::OP_TERM_DIV: begin mul_a = term_recip(n_q); mul_b = tmp_q;  end
			gdcd_pkg::OP_EXP_STEP: begin
				mul_a = 64'(e_q);
				mul_b = gdcd_pkg::EXP_M1_Q32;
			end
			gdcd_pkg::OP_WEIGHT:   begin mul_a = 64'(f_q);    mul_b = w_q;        end
			gdcd_pkg::OP_MOMENT:   begin mul_a = 64'(p_q);    mul_b = xmag;       end
			gdcd_pkg::OP_CHARGE:   begin mul_a = 64'(s_q);    mul_b = cscale_q;   end
			gdcd_pkg::OP_DERIV:    begin mul_a = 64'(dmag);   mul_b = dscale_q;   end
			default: ;
		endcase
		unique case (cmd.op)
			gdcd_pkg::OP_VOLT, gdcd_pkg::OP_ARG, gdcd_pkg::OP_TERM_MUL,
			gdcd_pkg::OP_TERM_DIV, gdcd_pkg::OP_EXP_STEP, gdcd_pkg::OP_WEIGHT,
			gdcd_pkg::OP_MOMENT, gdcd_pkg::OP_CHARGE, gdcd_pkg::OP_DERIV:
				mul_start = cmd.start;
			default: mul_start = 1'b0;
		endcase
	end

	assign div_start = cmd.start && (cmd.op == gdcd_pkg::OP_RECIP) && !e_q[32];
	assign div_rem   = e_q;
	assign div_low   = '0;
	assign div_nbits = 6'd32;
	assign div_dv    = {1'b1, e_q[31:0]};

	always_comb begin
		unique case (cmd.op)
			gdcd_pkg::OP_LOAD, gdcd_pkg::OP_READ, gdcd_pkg::OP_FLAGS,
			gdcd_pkg::OP_CLAMP, gdcd_pkg::OP_NEXT: single_op = 1'b1;
			gdcd_pkg::OP_RECIP: single_op = e_q[32];
			default: single_op = 1'b0;
		endcase
	end

	gdcd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	gdcd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.low_bits (div_low),
		.nbits    (div_nbits),
		.divisor  (div_dv),
		.done     (div_done),
		.quot     (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_cfg_q <= 5'd1;
			qkt_q       <= 32'd2534491;
			nscale_q    <= 32'd65536;
			cscale_q    <= 32'd16777216;
			dscale_q    <= 32'd16777216;
			op_q        <= gdcd_pkg::OP_LOAD;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (gdcd_pkg::reg_index_t'(cfg_index))
					gdcd_pkg::REG_NODE_COUNT:       count_cfg_q <= cfg_data[4:0];
					gdcd_pkg::REG_Q_OVER_KT:        qkt_q       <= cfg_data;
					gdcd_pkg::REG_NODE_SCALE:       nscale_q    <= cfg_data;
					gdcd_pkg::REG_CHARGE_SCALE:     cscale_q    <= cfg_data;
					gdcd_pkg::REG_DERIVATIVE_SCALE: dscale_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.start) op_q <= cmd.op;
			done_q <= (cmd.start && single_op) || mul_done || div_done;
			if (cmd.start && cmd.op == gdcd_pkg::OP_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// node tables
	always_ff @(posedge clk) begin
		if (cmd.start && cmd.op == gdcd_pkg::OP_LOAD && load_ok) begin
			val_mem[gdcd_pkg::IDX_W'(ld_idx_q)] <= ld_val_q;
			wgt_mem[gdcd_pkg::IDX_W'(ld_idx_q)] <= ld_wgt_q;
		end
		if (cmd.start && cmd.op == gdcd_pkg::OP_READ) begin
			x_q <= val_mem[idx_q];
			w_q <= wgt_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ld_idx_q <= node_index;
			ld_val_q <= node_value;
			ld_wgt_q <= node_weight;
			volt_q   <= voltage;
		end
		if (cmd.start) begin
			unique case (cmd.op)
				gdcd_pkg::OP_VOLT: begin
					s_q   <= '0;
					d_q   <= '0;
					idx_q <= '0;
				end
				gdcd_pkg::OP_FLAGS: begin
					cneg_q <= c_q[63];
					sat_q  <= (c_q >= FERMI_LIM) || (c_q <= -FERMI_LIM);
					f_q    <= (c_q >= FERMI_LIM) ? 33'd0 : gdcd_pkg::ONE_Q32;
					r_q    <= cmag_u[31:0];
					k_q    <= cmag_u[36:32];
					term_q <= gdcd_pkg::ONE_Q32;
					sum_q  <= $signed({3'd0, gdcd_pkg::ONE_Q32});
					n_q    <= gdcd_pkg::TERM_W'(1);
				end
				gdcd_pkg::OP_CLAMP: begin
					e_q  <= e_clamp;
					kc_q <= k_q;
				end
				gdcd_pkg::OP_RECIP: if (e_q[32]) f_q <= gdcd_pkg::HALF_Q32;
				gdcd_pkg::OP_NEXT: idx_q <= idx_q + gdcd_pkg::IDX_W'(1);
				default: ;
			endcase
		end
		if (mul_done) begin
			unique case (op_q)
				gdcd_pkg::OP_VOLT:
					bmag_q <= (prod[63:0] > (64'd1 << 60)) ? (61'd1 << 60) : prod[60:0];
				gdcd_pkg::OP_ARG: c_q <= a_s - b_s;
				gdcd_pkg::OP_TERM_MUL: tmp_q <= prod[63:32];
				gdcd_pkg::OP_TERM_DIV: begin
					term_q <= {1'b0, prod[71:40]};
					if (n_q[0]) sum_q <= sum_q - $signed({4'd0, prod[71:40]});
					else sum_q <= sum_q + $signed({4'd0, prod[71:40]});
					n_q <= n_q + gdcd_pkg::TERM_W'(1);
				end
				gdcd_pkg::OP_EXP_STEP: begin
					e_q  <= prod[64:32];
					kc_q <= kc_q - 5'd1;
				end
				gdcd_pkg::OP_WEIGHT: begin
					p_q <= prod[64:24];
					s_q <= s_q + gdcd_pkg::S_W'(prod[64:24]);
				end
				gdcd_pkg::OP_MOMENT: begin
					if (xneg) d_q <= d_q - $signed(gdcd_pkg::D_W'(prod[71:28]));
					else d_q <= d_q + $signed(gdcd_pkg::D_W'(prod[71:28]));
				end
				gdcd_pkg::OP_CHARGE: res_c_q <= over ? 48'h8000_0000_0000 : (48'd0 - mag48);
				gdcd_pkg::OP_DERIV: begin
					if (d_q[gdcd_pkg::D_W-1]) begin
						res_d_q <= over ? 48'h8000_0000_0000 : (48'd0 - mag48);
					end else begin
						res_d_q <= over ? 48'h7FFF_FFFF_FFFF : mag48;
					end
				end
				default: ;
			endcase
		end
		if (div_done) begin
			unique case (op_q)
				gdcd_pkg::OP_RECIP:
					f_q <= cneg_q ? (gdcd_pkg::ONE_Q32 - {1'b0, quot[31:0]}) : {1'b0, quot[31:0]};
				default: ;
			endcase
		end
		if (cmd.start && cmd.op == gdcd_pkg::OP_PUSH) begin
			out_c_q <= res_c_q;
			out_d_q <= res_d_q;
		end
	end

	assign status.done      = done_q;
	assign status.no_nodes  = count_eff == '0;
	assign status.node_last = (gdcd_pkg::CNT_W'(idx_q) + gdcd_pkg::CNT_W'(1)) == count_eff;
	assign status.term_end  = n_q > gdcd_pkg::TERM_W'(gdcd_pkg::TAYLOR_TERMS);
	assign status.k_zero    = kc_q == 5'd0;
	assign status.saturated = sat_q;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid         = out_valid_q;
	assign charge_density    = out_c_q;
	assign charge_derivative = out_d_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_done && div_done))
		else $error("multiplier and divider finished together");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start && cmd.op == gdcd_pkg::OP_PUSH) |-> (!out_valid_q || out_ready))
		else $error("result pushed over an unsent result");

	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start && cmd.op == gdcd_pkg::OP_PUSH) |=> out_valid_q)
		else $error("pushed result not presented");

endmodule

// ===== rtl/gdcd_ctrl.sv =====
module gdcd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_operation,
	output logic              in_ready,
	input  gdcd_pkg::status_t status,
	output gdcd_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_LOAD, ST_VOLT, ST_READ, ST_ARG, ST_FLAGS, ST_TERM_MUL, ST_TERM_DIV,
		ST_CLAMP, ST_EXP_STEP, ST_RECIP, ST_WEIGHT, ST_MOMENT, ST_NEXT, ST_CHARGE,
		ST_DERIV, ST_OUT
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   issued_q;

	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.start   = 1'b0;
		cmd.op      = gdcd_pkg::OP_LOAD;
		state_nx    = ST_IDLE;
		unique case (state_q)
			ST_IDLE:     state_nx = in_operation ? ST_LOAD : ST_VOLT;
			ST_LOAD:     begin cmd.op = gdcd_pkg::OP_LOAD;  state_nx = ST_IDLE; end
			ST_VOLT: begin
				cmd.op   = gdcd_pkg::OP_VOLT;
				state_nx = status.no_nodes ? ST_CHARGE : ST_READ;
			end
			ST_READ:     begin cmd.op = gdcd_pkg::OP_READ;  state_nx = ST_ARG;   end
			ST_ARG:      begin cmd.op = gdcd_pkg::OP_ARG;   state_nx = ST_FLAGS; end
			ST_FLAGS: begin
				cmd.op   = gdcd_pkg::OP_FLAGS;
				state_nx = status.saturated ? ST_WEIGHT : ST_TERM_MUL;
			end
			ST_TERM_MUL: begin cmd.op = gdcd_pkg::OP_TERM_MUL; state_nx = ST_TERM_DIV; end
			ST_TERM_DIV: begin
				cmd.op   = gdcd_pkg::OP_TERM_DIV;
				state_nx = status.term_end ? ST_CLAMP : ST_TERM_MUL;
			end
			ST_CLAMP: begin
				cmd.op   = gdcd_pkg::OP_CLAMP;
				state_nx = status.k_zero ? ST_RECIP : ST_EXP_STEP;
			end
			ST_EXP_STEP: begin
				cmd.op   = gdcd_pkg::OP_EXP_STEP;
				state_nx = status.k_zero ? ST_RECIP : ST_EXP_STEP;
			end
			ST_RECIP:    begin cmd.op = gdcd_pkg::OP_RECIP;  state_nx = ST_WEIGHT; end
			ST_WEIGHT:   begin cmd.op = gdcd_pkg::OP_WEIGHT; state_nx = ST_MOMENT; end
			ST_MOMENT: begin
				cmd.op   = gdcd_pkg::OP_MOMENT;
				state_nx = status.node_last ? ST_CHARGE : ST_NEXT;
			end
			ST_NEXT:     begin cmd.op = gdcd_pkg::OP_NEXT;   state_nx = ST_READ;  end
			ST_CHARGE:   begin cmd.op = gdcd_pkg::OP_CHARGE; state_nx = ST_DERIV; end
			ST_DERIV:    begin cmd.op = gdcd_pkg::OP_DERIV;  state_nx = ST_OUT;   end
			ST_OUT:      begin cmd.op = gdcd_pkg::OP_PUSH;   state_nx = ST_IDLE;  end
			default:     state_nx = ST_IDLE;
		endcase
		if (state_q == ST_OUT) begin
			cmd.start = status.out_free;
		end else if (state_q != ST_IDLE) begin
			cmd.start = !issued_q;
		end
	end

	assign in_ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			priority if (state_q == ST_IDLE) begin
				issued_q <= 1'b0;
				if (in_valid) state_q <= state_nx;
			end else if (state_q == ST_OUT) begin
				issued_q <= 1'b0;
				if (status.out_free) state_q <= state_nx;
			end else if (status.done) begin
				issued_q <= 1'b0;
				state_q  <= state_nx;
			end else begin
				issued_q <= 1'b1;
			end
		end
	end

endmodule

// ===== tb/sv/gdcd_tb_pkg.sv =====
package gdcd_tb_pkg;

	typedef enum logic {
		OPER_EVALUATE = 1'b0,
		OPER_LOAD     = 1'b1
	} oper_t;

	localparam logic [4:0]  NODE_COUNT_RESET = 5'd1;
	localparam logic [31:0] Q_OVER_KT_RESET = 32'd2534491;
	localparam logic [31:0] NODE_SCALE_RESET = 32'd65536;
	localparam logic [31:0] SCALE_RESET = 32'd16777216;

endpackage

// ===== tb/sv/gaussian_dos_charge_density_check.sv =====
module gaussian_dos_charge_density_check (
	input  logic                           clk,
	input  logic                           arst_n,
	gdcd_in_if                             in_ch,
	gdcd_out_if                            out_ch,
	input  logic                           cfg_we,
	input  logic [gdcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output int                             fail_count,
	output int                             pending
);
	import gdcd_tb_pkg::*;

	typedef struct packed {
		logic signed [47:0] charge_density;
		logic signed [47:0] charge_derivative;
	} density_t;

	localparam logic [63:0] ONE = 64'h1_0000_0000;
	localparam logic [63:0] OUT_MAX = 64'h7FFF_FFFF_FFFF;
	localparam logic [63:0] OUT_MIN_MAG = 64'h8000_0000_0000;

	logic [4:0]  node_count_r;
	logic [31:0] q_over_kt_r;
	logic [31:0] node_scale_r;
	logic [31:0] charge_scale_r;
	logic [31:0] derivative_scale_r;
	logic [31:0] abscissa [16];
	logic [31:0] weight [16];
	density_t    density_queue [$];

	assign pending = density_queue.size();

	function automatic logic [63:0] exp_neg_q32(input logic [63:0] u);
		logic [63:0] r;
		logic [63:0] k;
		logic [63:0] term;
		logic [63:0] e;
		longint      sum;
		r = {32'd0, u[31:0]};
		k = u >> 32;
		term = ONE;
		sum = longint'(ONE);
		for (int n = 1; n <= 13; n++) begin
			term = ((term * r) >> 32) / 64'(n);
			if (n % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > longint'(ONE)) sum = longint'(ONE);
		e = 64'(sum);
		for (logic [63:0] i = 0; i < k; i++)
			e = (e * {32'd0, gdcd_pkg::EXP_M1_Q32}) >> 32;
		return e;
	endfunction

	function automatic logic [63:0] fermi_q32(input longint c);
		longint      lim;
		logic [63:0] u;
		logic [63:0] e;
		logic [63:0] g;
		lim = longint'(32) <<< 32;
		if (c >= lim) return 64'd0;
		if (c <= -lim) return ONE;
		u = (c < 0) ? 64'(-c) : 64'(c);
		e = exp_neg_q32(u);
		if (e >= ONE) g = ONE >> 1;
		else g = (e << 32) / (ONE + e);
		return (c < 0) ? ONE - g : g;
	endfunction

	function automatic logic [47:0] saturate48(input bit neg, input logic [63:0] mag);
		logic [63:0] m;
		m = mag;
		if (neg) begin
			if (m >= OUT_MIN_MAG) m = OUT_MIN_MAG;
			m = 64'd0 - m;
			return m[47:0];
		end
		if (m > OUT_MAX) m = OUT_MAX;
		return m[47:0];
	endfunction

	function automatic density_t predict_density(input logic signed [31:0] v);
		density_t     res;
		longint       vl;
		longint       xl;
		longint       b;
		longint       a;
		longint       d_sum;
		logic [63:0]  vmag;
		logic [63:0]  bmag;
		logic [63:0]  xmag;
		logic [63:0]  amag;
		logic [63:0]  f;
		logic [63:0]  p;
		logic [63:0]  t;
		logic [63:0]  s_sum;
		logic [63:0]  mag;
		logic [127:0] wide;
		int           count;
		vl = longint'(v);
		vmag = (vl < 0) ? 64'(-vl) : 64'(vl);
		bmag = vmag * {32'd0, q_over_kt_r};
		if (bmag > (64'd1 << 60)) bmag = 64'd1 << 60;
		b = (vl < 0) ? -longint'(bmag) : longint'(bmag);
		count = node_count_r;
		if (count > 16) count = 16;
		s_sum = 0;
		d_sum = 0;
		for (int i = 0; i < count; i++) begin
			xl = longint'($signed(abscissa[i]));
			xmag = (xl < 0) ? 64'(-xl) : 64'(xl);
			amag = (xmag * {32'd0, node_scale_r}) >> 12;
			a = (xl < 0) ? -longint'(amag) : longint'(amag);
			f = fermi_q32(a - b);
			p = ({32'd0, weight[i]} * f) >> 24;
			wide = 128'(p);
			wide = wide * 128'(xmag);
			t = 64'(wide >> 28);
			s_sum = s_sum + p;
			if (xl < 0) d_sum = d_sum - longint'(t);
			else d_sum = d_sum + longint'(t);
		end
		wide = 128'(s_sum);
		wide = wide * 128'(charge_scale_r);
		res.charge_density = saturate48(1'b1, 64'(wide >> 24));
		mag = (d_sum < 0) ? 64'(-d_sum) : 64'(d_sum);
		wide = 128'(mag);
		wide = wide * 128'(derivative_scale_r);
		res.charge_derivative = saturate48(d_sum < 0, 64'(wide >> 24));
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		density_t want;
		int       errs;
		errs = 0;
		if (!arst_n) begin
			node_count_r <= NODE_COUNT_RESET;
			q_over_kt_r <= Q_OVER_KT_RESET;
			node_scale_r <= NODE_SCALE_RESET;
			charge_scale_r <= SCALE_RESET;
			derivative_scale_r <= SCALE_RESET;
			fail_count <= 0;
			density_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gdcd_pkg::REG_NODE_COUNT:       node_count_r <= cfg_data[4:0];
					gdcd_pkg::REG_Q_OVER_KT:        q_over_kt_r <= cfg_data;
					gdcd_pkg::REG_NODE_SCALE:       node_scale_r <= cfg_data;
					gdcd_pkg::REG_CHARGE_SCALE:     charge_scale_r <= cfg_data;
					gdcd_pkg::REG_DERIVATIVE_SCALE: derivative_scale_r <= cfg_data;
					default: ;
				endcase
			end
			// result transfer
			if (out_ch.valid && out_ch.ready) begin
				if (density_queue.size() == 0) begin
					$error("unexpected result transfer");
					errs++;
				end else begin
					want = density_queue.pop_front();
					if (out_ch.charge_density !== want.charge_density) begin
						$error("charge_density expected %0d actual %0d",
							want.charge_density, out_ch.charge_density);
						errs++;
					end
					if (out_ch.charge_derivative !== want.charge_derivative) begin
						$error("charge_derivative expected %0d actual %0d",
							want.charge_derivative, out_ch.charge_derivative);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
			// item transfer
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.operation == OPER_LOAD) begin
					abscissa[in_ch.node_index] <= in_ch.node_value;
					weight[in_ch.node_index] <= in_ch.node_weight;
				end else begin
					density_queue.push_back(predict_density(in_ch.voltage));
				end
			end
		end
	end

endmodule

// ===== tb/sv/gaussian_dos_charge_density_tb.sv =====
module gaussian_dos_charge_density_tb;
	import gdcd_tb_pkg::*;

	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam int HOLD_CYCLES = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          fails;
	int          pending;
	bit          idling;
	bit          hold_req;
	longint      cycles;

	gdcd_in_if  in_ch ();
	gdcd_out_if out_ch ();

	gaussian_dos_charge_density dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gaussian_dos_charge_density_check chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fails),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// receiver with random stalls and one long hold-off
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ch.ready = idling ? ($urandom_range(99) >= 11) : 1'b1;
		end
	end

	task automatic send_item(input oper_t op, input logic [3:0] idx,
		input logic [31:0] x, input logic [31:0] w, input logic [31:0] v);
		while (idling && $urandom_range(99) < 11) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.operation = op;
		in_ch.node_index = idx;
		in_ch.node_value = x;
		in_ch.node_weight = w;
		in_ch.voltage = v;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input gdcd_pkg::reg_index_t idx, input logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		in_ch.valid = 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_voltage(input int big_pct);
		int r;
		r = $urandom_range(99);
		if (r < big_pct) return $urandom();
		if (r < big_pct + 10) return 32'($signed($urandom_range(8000)) - 4000);
		return 32'($signed($urandom_range(120000)) - 60000);
	endfunction

	task automatic random_items(input int count, input int big_pct);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 50)
				send_item(OPER_LOAD, 4'($urandom_range(15)), $urandom(), $urandom(), $urandom());
			else
				send_item(OPER_EVALUATE, 4'($urandom()), $urandom(), $urandom(),
					pick_voltage(big_pct));
		end
	endtask

	task automatic set_regs(input logic [4:0] cnt, input logic [31:0] qk,
		input logic [31:0] ns, input logic [31:0] cs, input logic [31:0] ds);
		write_reg(gdcd_pkg::REG_NODE_COUNT, {27'd0, cnt});
		write_reg(gdcd_pkg::REG_Q_OVER_KT, qk);
		write_reg(gdcd_pkg::REG_NODE_SCALE, ns);
		write_reg(gdcd_pkg::REG_CHARGE_SCALE, cs);
		write_reg(gdcd_pkg::REG_DERIVATIVE_SCALE, ds);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idling = 1'b1;
		hold_req = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.operation = OPER_EVALUATE;
		in_ch.node_index = '0;
		in_ch.node_value = '0;
		in_ch.node_weight = '0;
		in_ch.voltage = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every slot loaded before any evaluate, extremes in the first ones
		send_item(OPER_LOAD, 4'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_item(OPER_LOAD, 4'd1, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0);
		send_item(OPER_LOAD, 4'd2, 32'd0, 32'd0, 32'd0);
		send_item(OPER_LOAD, 4'd3, 32'h1000_0000, 32'h0100_0000, 32'd0);
		for (int i = 4; i < 16; i++)
			send_item(OPER_LOAD, 4'(i), $urandom(), $urandom(), $urandom());
		send_item(OPER_EVALUATE, 4'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
		send_item(OPER_EVALUATE, 4'd0, 32'd0, 32'd0, 32'h8000_0000);
		send_item(OPER_EVALUATE, 4'd0, 32'd0, 32'd0, 32'd0);
		send_item(OPER_EVALUATE, 4'd0, 32'd0, 32'd0, 32'd1);
		send_item(OPER_EVALUATE, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
		send_item(OPER_EVALUATE, 4'd0, 32'd0, 32'd0, 32'd13000);
		send_item(OPER_LOAD, 4'd0, 32'hF000_0000, 32'h0000_0001, 32'd0);
		send_item(OPER_EVALUATE, 4'd0, 32'd0, 32'd0, 32'hFFFF_9000);
		drain();

		// no nodes, zero argument scales, largest output scales
		set_regs(5'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_items(120, 30);
		drain();

		// count above the table, taken as full table
		set_regs(5'd31, Q_OVER_KT_RESET, NODE_SCALE_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_items(40, 90);
		drain();
		set_regs(5'd17, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SCALE_RESET, SCALE_RESET);
		random_items(20, 50);
		drain();

		// long receiver hold-off while items keep coming
		set_regs(5'd3, Q_OVER_KT_RESET, $urandom_range(200000), $urandom(), $urandom());
		hold_req = 1'b1;
		random_items(170, 40);
		drain();

		// no idling in this stretch
		idling = 1'b0;
		set_regs(5'd2, $urandom(), $urandom(), $urandom(), $urandom());
		random_items(150, 30);
		drain();
		idling = 1'b1;

		set_regs(5'd4, Q_OVER_KT_RESET, NODE_SCALE_RESET, 32'd0, 32'd0);
		random_items(150, 40);
		drain();

		set_regs(5'd1, $urandom_range(5000000), $urandom_range(300000), $urandom(),
			$urandom());
		random_items(150, 30);
		drain();

		repeat (100) @(posedge clk);
		if (fails == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
